[hdl/twa_pkg.sv]
// Shared types and constants for the Tukey window applier.
// Holds register indexes, field widths and the reset values of the configuration.
// No dependencies.
`default_nettype none

package twa_pkg;

  // Parameter defaults for the top level.
  localparam int SAMPLE_BITS_DEF     = 16;
  localparam int COS_TABLE_DEPTH_DEF = 1024;
  localparam int MAX_FRAME_DEF       = 65536;

  // Fixed field widths.
  localparam int FRAME_LEN_W = 17;
  localparam int TAPER_W     = 16;
  localparam int PHASE_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int COEF_W      = 16;
  localparam int COS_W       = 17;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Bits of the phase word below the quadrant bits.
  localparam int QUAD_FRAC_W = 30;

  // Reset values of the configuration registers.
  localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST  = FRAME_LEN_W'(1024);
  localparam logic [TAPER_W-1:0]     TAPER_RST      = TAPER_W'(64);
  localparam logic [PHASE_W-1:0]     PHASE_STEP_RST = PHASE_W'(33554432);

  // Cosine table generation constants (Q30 Taylor series).
  localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
  localparam logic [63:0] ONE_Q30      = 64'd1073741824;
  localparam int          TAYLOR_TERMS = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_TAPER_LIMIT  = 2'd1,
    REG_PHASE_STEP   = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

[hdl/twa_cos_rom.sv]
// Quarter-wave cosine ROM, Q1.16 entries, with a registered read port.
// The table is built at elaboration by a Q30 Taylor series; depends on twa_pkg.
`default_nettype none

module twa_cos_rom
  import twa_pkg::*;
#(
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
  parameter int AW              = $clog2(COS_TABLE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [COS_W-1:0] rd_data
);

  typedef logic [COS_W-1:0] tab_t [COS_TABLE_DEPTH+1];

  // Each entry is cos(pi/2 * k / depth), clamped at zero and rounded half up to Q16.
  function automatic tab_t build_tab();
    tab_t        t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / 64'(COS_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      acc  = longint'(ONE_Q30);
      for (int n = 1; n <= TAYLOR_TERMS; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      t[k] = COS_W'((acc + 64'sd8192) >>> 14);
    end
    return t;
  endfunction

  localparam tab_t COS_TAB = build_tab();

  // Registered read.
  always_ff @(posedge clk) begin
    rd_data <= COS_TAB[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/tukey_window_applier_unit.sv]
// Top level of the Tukey window applier: configuration registers and sample pipeline.
// Depends on twa_pkg and twa_cos_rom.
//
// The unit takes one sample per clock: busy never rises, so a beat is accepted on every
// cycle that start is high. Each beat gives exactly one result on out_sample_out,
// marked by out_valid for one cycle. Results leave in the order the beats came in.
// Each beat passes through the input register, six processing stages (distance,
// phase multiply, table index multiply, ROM read, coefficient, sample multiply) and
// the output register, which also rounds and saturates. The configuration port is
// always ready; write it only while no beat is in flight.
`default_nettype none

module tukey_window_applier_unit
  import twa_pkg::*;
#(
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
  parameter int MAX_FRAME       = MAX_FRAME_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Sample input channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic        [INDEX_W-1:0]     in_sample_index,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_in,
  // Result channel
  output logic                               out_valid,
  output logic signed      [SAMPLE_BITS-1:0] out_sample_out,
  // Configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic        [CFG_DATA_W-1:0]  cfg_data
);

  localparam int MF_W = $clog2(MAX_FRAME + 1);
  localparam int NW   = (MF_W > FRAME_LEN_W) ? MF_W : FRAME_LEN_W;
  localparam int AW   = $clog2(COS_TABLE_DEPTH + 1);
  localparam int SW   = QUAD_FRAC_W + AW;
  localparam int PW   = SAMPLE_BITS + COEF_W + 1;
  localparam int YW   = SAMPLE_BITS + 1;

  localparam logic [NW-1:0]    MAX_FRAME_N = NW'(MAX_FRAME);
  localparam logic [AW-1:0]    DEPTH_A     = AW'(COS_TABLE_DEPTH);
  localparam logic [17:0]      COEF_BIAS   = 18'd65537;
  localparam logic [COEF_W-1:0] COEF_MAX   = {COEF_W{1'b1}};
  localparam logic signed [PW-1:0] ROUND_HALF = PW'(32768);

  // Handshake outputs: the pipeline never stalls.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic in_fire;
  assign in_fire = start && !busy;

  // Configuration registers.
  logic [FRAME_LEN_W-1:0] frame_length_r;
  logic [TAPER_W-1:0]     taper_limit_r;
  logic [PHASE_W-1:0]     phase_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LEN_RST;
      taper_limit_r  <= TAPER_RST;
      phase_step_r   <= PHASE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_LENGTH: frame_length_r <= cfg_data[FRAME_LEN_W-1:0];
        REG_TAPER_LIMIT:  taper_limit_r  <= cfg_data[TAPER_W-1:0];
        REG_PHASE_STEP:   phase_step_r   <= cfg_data[PHASE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length and taper limit, clamped and registered.
  logic [NW-1:0]      n_eff_nxt, n_eff_r;
  logic [NW-1:0]      n_half;
  logic [TAPER_W-1:0] lim_eff_nxt, lim_eff_r;

  always_comb begin
    n_eff_nxt = (NW'(frame_length_r) > MAX_FRAME_N) ? MAX_FRAME_N : NW'(frame_length_r);
    n_half    = n_eff_nxt >> 1;
    if (NW'(taper_limit_r) > n_half) begin
      lim_eff_nxt = n_half[TAPER_W-1:0];
    end else begin
      lim_eff_nxt = taper_limit_r;
    end
  end

  always_ff @(posedge clk) begin
    n_eff_r   <= n_eff_nxt;
    lim_eff_r <= lim_eff_nxt;
  end

  // Valid bits for each stage.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  // Stage 1: input register.
  logic        [INDEX_W-1:0]     idx1_r;
  logic signed [SAMPLE_BITS-1:0] smp1_r;

  always_ff @(posedge clk) begin
    idx1_r <= in_sample_index;
    smp1_r <= in_sample_in;
  end

  // Stage 2: distance to the nearer frame end and the taper decision.
  logic                          in_frame;
  logic        [NW-1:0]          back;
  logic        [INDEX_W-1:0]     d_nxt, d2_r;
  logic                          tap_nxt, tap2_r;
  logic signed [SAMPLE_BITS-1:0] smp2_r;

  always_comb begin
    in_frame = NW'(idx1_r) < n_eff_r;
    back     = n_eff_r - NW'(1) - NW'(idx1_r);
    if (NW'(idx1_r) < back) begin
      d_nxt = idx1_r;
    end else begin
      d_nxt = back[INDEX_W-1:0];
    end
    tap_nxt = in_frame && (d_nxt < lim_eff_r);
  end

  always_ff @(posedge clk) begin
    d2_r   <= d_nxt;
    tap2_r <= tap_nxt;
    smp2_r <= smp1_r;
  end

  // Stage 3: phase in turns, modulo one full turn.
  logic        [PHASE_W-1:0]     p_nxt, p3_r;
  logic                          tap3_r;
  logic signed [SAMPLE_BITS-1:0] smp3_r;

  assign p_nxt = PHASE_W'(PHASE_W'(d2_r) * phase_step_r);

  always_ff @(posedge clk) begin
    p3_r   <= p_nxt;
    tap3_r <= tap2_r;
    smp3_r <= smp2_r;
  end

  // Stage 4: table index within the quadrant, mirrored for odd quadrants.
  logic        [SW-1:0]          scaled;
  logic        [AW-1:0]          tab_i;
  logic        [1:0]             quad;
  logic        [AW-1:0]          addr_nxt, addr4_r;
  logic                          neg4_r, tap4_r;
  logic signed [SAMPLE_BITS-1:0] smp4_r;

  always_comb begin
    quad     = p3_r[PHASE_W-1:QUAD_FRAC_W];
    scaled   = SW'(p3_r[QUAD_FRAC_W-1:0]) * SW'(COS_TABLE_DEPTH);
    tab_i    = scaled[SW-1:QUAD_FRAC_W];
    addr_nxt = quad[0] ? (DEPTH_A - tab_i) : tab_i;
  end

  always_ff @(posedge clk) begin
    addr4_r <= addr_nxt;
    neg4_r  <= quad[1] ^ quad[0];
    tap4_r  <= tap3_r;
    smp4_r  <= smp3_r;
  end

  // Stage 5: cosine ROM read.
  logic        [COS_W-1:0]       cos5;
  logic                          neg5_r, tap5_r;
  logic signed [SAMPLE_BITS-1:0] smp5_r;

  twa_cos_rom #(
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH),
    .AW             (AW)
  ) u_cos_rom (
    .clk    (clk),
    .rd_addr(addr4_r),
    .rd_data(cos5)
  );

  always_ff @(posedge clk) begin
    neg5_r <= neg4_r;
    tap5_r <= tap4_r;
    smp5_r <= smp4_r;
  end

  // Stage 6: window coefficient w = (1 - cos) / 2 in Q0.16, capped at full scale.
  logic        [17:0]            coef_sum;
  logic        [16:0]            coef_half;
  logic        [COEF_W-1:0]      w_nxt, w6_r;
  logic                          tap6_r;
  logic signed [SAMPLE_BITS-1:0] smp6_r;

  always_comb begin
    if (neg5_r) begin
      coef_sum = COEF_BIAS + 18'(cos5);
    end else begin
      coef_sum = COEF_BIAS - 18'(cos5);
    end
    coef_half = coef_sum[17:1];
    if (coef_half > 17'(COEF_MAX)) begin
      w_nxt = COEF_MAX;
    end else begin
      w_nxt = coef_half[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    w6_r   <= w_nxt;
    tap6_r <= tap5_r;
    smp6_r <= smp5_r;
  end

  // Stage 7: product with the rounding bias.
  logic signed [PW-1:0]          prod_nxt, prod7_r;
  logic                          tap7_r;
  logic signed [SAMPLE_BITS-1:0] smp7_r;

  assign prod_nxt = PW'(smp6_r) * PW'(signed'({1'b0, w6_r})) + ROUND_HALF;

  always_ff @(posedge clk) begin
    prod7_r <= prod_nxt;
    tap7_r  <= tap6_r;
    smp7_r  <= smp6_r;
  end

  // Output stage: floor shift, saturation and pass-through select.
  logic signed [PW-1:0]          shifted;
  logic        [YW-1:0]          y_full;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic signed [SAMPLE_BITS-1:0] out_sample_nxt, out_sample_r;

  always_comb begin
    shifted = prod7_r >>> COEF_W;
    y_full  = shifted[YW-1:0];
    if (y_full[YW-1] != y_full[YW-2]) begin
      y_sat = y_full[YW-1] ? signed'({1'b1, {(SAMPLE_BITS-1){1'b0}}})
                           : signed'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    end else begin
      y_sat = signed'(y_full[SAMPLE_BITS-1:0]);
    end
    out_sample_nxt = tap7_r ? y_sat : smp7_r;
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

  // A result appears only for a beat that was accepted.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(in_fire, 8))
    else $error("result without a matching accepted beat");

  // A tapered distance always lies in the lower half of the largest frame.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && tap2_r) |-> (d2_r[INDEX_W-1] == 1'b0))
    else $error("tapered distance beyond half frame");

  // Tapering never grows a sample or flips its sign.
  a_taper_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (v7_r && tap7_r) |=>
      (($past(smp7_r) >= 0) ? (out_sample_r >= 0 && out_sample_r <= $past(smp7_r))
                            : (out_sample_r <= 0 && out_sample_r >= $past(smp7_r))))
    else $error("tapered sample outside input magnitude");

endmodule

`default_nettype wire
